// ===== hw/rtl/skt_pkg.sv =====
// skt_pkg: widths, command and status codes for the sorted key table
// no dependencies; imported by sorted_key_table_unit
package skt_pkg;

    localparam int SKT_DEPTH = 256;

    localparam int KEY_W    = 16;
    localparam int DATA_W   = 16;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + 3 * DATA_W;

    localparam int IN_FIELDS_W  = CMD_W + KEY_W + 3 * DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + POS_W + 4 * DATA_W + STATUS_W + POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_FREE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/sorted_key_table_unit.sv =====
// sorted_key_table_unit: table of entries kept in ascending key order
// depends on skt_pkg; holds the entry memory and the search/shift sequencer
//
// usage: one command transaction enters on the s_* stream, one result
// transaction leaves on the m_* stream. commands are insert or replace,
// remove, lookup and next free key. max_key must be written through cfg_we
// and cfg_wdata only while the block is idle; the block does not check it.
// each probe of a binary search over the filled entries is one memory
// read and one compare. insert of a new key then moves every later
// entry up one place and remove moves them down, one entry per cycle
// over the single memory port. s_tready is high only between commands;
// a result waits in the output register and a new command is taken
// meanwhile, but its result is not loaded until m_tready frees that
// register.
// reset empties the table and sets max_key to 65535; the memory itself
// is not cleared and needs no clearing pass.
module sorted_key_table_unit #(
    parameter int DEPTH = skt_pkg::SKT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [skt_pkg::KEY_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command, key, room, start_day, nights
    input  logic [skt_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found, position, room_out, start_day_out, nights_out, free_key,
    // status, entry_count
    output logic [skt_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import skt_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE_CMP,
        S_SEARCH,
        S_CMP,
        S_ACT,
        S_SHIFT,
        S_DRAIN,
        S_WRITE_NEW,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [DATA_W-1:0]      room_reg, room_next;
    logic [DATA_W-1:0]      day_reg, day_next;
    logic [DATA_W-1:0]      nts_reg, nts_next;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [AW-1:0]          src_reg, src_next;
    logic [AW-1:0]          dst_reg, dst_next;
    logic [AW-1:0]          end_reg, end_next;
    logic                   up_reg, up_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [KEY_W-1:0]       max_key_reg, max_key_next;
    logic                   found_reg, found_next;
    status_t                status_reg, status_next;
    logic [DATA_W-1:0]      res_room_reg, res_room_next;
    logic [DATA_W-1:0]      res_day_reg, res_day_next;
    logic [DATA_W-1:0]      res_nts_reg, res_nts_next;
    logic [KEY_W-1:0]       res_free_reg, res_free_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [ENTRY_W-1:0]     mem [DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_W-1:0]     wr_data;

    logic [CNT_W:0]         mid_sum;
    logic [AW-1:0]          mid;
    logic [CNT_W-1:0]       cnt_m1;
    logic [KEY_W-1:0]       probe_key;
    logic [KEY_W:0]         free_sum;
    cmd_t                   in_cmd;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[AW:1];
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign probe_key = rd_data_reg[KEY_W-1:0];
    assign free_sum  = {1'b0, probe_key} + (KEY_W + 1)'(1);
    assign in_cmd    = cmd_t'(s_tdata[CMD_W-1:0]);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        room_next     = room_reg;
        day_next      = day_reg;
        nts_next      = nts_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        pos_next      = pos_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        end_next      = end_reg;
        up_next       = up_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        max_key_next  = max_key_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        res_room_next = res_room_reg;
        res_day_next  = res_day_reg;
        res_nts_next  = res_nts_reg;
        res_free_next = res_free_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        if (cfg_we)
        begin
            max_key_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = in_cmd;
                    key_next      = s_tdata[CMD_W +: KEY_W];
                    room_next     = s_tdata[CMD_W + KEY_W +: DATA_W];
                    day_next      = s_tdata[CMD_W + KEY_W + DATA_W +: DATA_W];
                    nts_next      = s_tdata[CMD_W + KEY_W + 2 * DATA_W +: DATA_W];
                    lo_next       = '0;
                    hi_next       = count_reg;
                    pos_next      = '0;
                    found_next    = 1'b0;
                    pend_next     = 1'b0;
                    status_next   = STAT_DONE;
                    res_room_next = '0;
                    res_day_next  = '0;
                    res_nts_next  = '0;
                    res_free_next = '0;
                    if (in_cmd == CMD_FREE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_free_next = (max_key_reg != '0) ? KEY_W'(1) : '0;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cnt_m1[AW-1:0];
                            state_next = S_FREE_CMP;
                        end
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_FREE_CMP:
            begin
                res_free_next = (free_sum > {1'b0, max_key_reg}) ? '0 : free_sum[KEY_W-1:0];
                state_next    = S_FINISH;
            end

            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid;
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    pos_next   = lo_reg;
                    found_next = 1'b0;
                    state_next = S_ACT;
                end
            end

            S_CMP:
            begin
                if (key_reg < probe_key)
                begin
                    hi_next    = CNT_W'(mid_reg);
                    state_next = S_SEARCH;
                end
                else if (key_reg > probe_key)
                begin
                    lo_next    = CNT_W'(mid_reg) + CNT_W'(1);
                    state_next = S_SEARCH;
                end
                else
                begin
                    found_next = 1'b1;
                    pos_next   = CNT_W'(mid_reg);
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_room_next = rd_data_reg[KEY_W +: DATA_W];
                        res_day_next  = rd_data_reg[KEY_W + DATA_W +: DATA_W];
                        res_nts_next  = rd_data_reg[KEY_W + 2 * DATA_W +: DATA_W];
                    end
                    state_next = S_ACT;
                end
            end

            S_ACT:
            begin
                state_next = S_FINISH;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (found_reg)
                        begin
                            state_next = S_WRITE_NEW;
                        end
                        else if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (pos_reg == count_reg)
                        begin
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_WRITE_NEW;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            up_next    = 1'b1;
                            src_next   = cnt_m1[AW-1:0];
                            end_next   = pos_reg[AW-1:0];
                            state_next = S_SHIFT;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = cnt_m1;
                            if (pos_reg + CNT_W'(1) != count_reg)
                            begin
                                up_next    = 1'b0;
                                src_next   = pos_reg[AW-1:0] + AW'(1);
                                end_next   = cnt_m1[AW-1:0];
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (!found_reg)
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_SHIFT:
            begin
                rd_en   = 1'b1;
                rd_addr = src_reg;
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data_reg;
                end
                pend_next = 1'b1;
                dst_next  = up_reg ? (src_reg + AW'(1)) : (src_reg - AW'(1));
                if (src_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    src_next = up_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                end
            end

            S_DRAIN:
            begin
                wr_en      = 1'b1;
                wr_addr    = dst_reg;
                wr_data    = rd_data_reg;
                pend_next  = 1'b0;
                state_next = up_reg ? S_WRITE_NEW : S_FINISH;
            end

            S_WRITE_NEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = {nts_reg, day_reg, room_reg, key_reg};
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({POS_W'(count_reg), status_reg, res_free_reg,
                                                 res_nts_reg, res_day_reg, res_room_reg,
                                                 POS_W'(pos_reg), found_reg});
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_INSERT;
            key_reg      <= '0;
            room_reg     <= '0;
            day_reg      <= '0;
            nts_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            mid_reg      <= '0;
            pos_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            end_reg      <= '0;
            up_reg       <= 1'b0;
            pend_reg     <= 1'b0;
            count_reg    <= '0;
            max_key_reg  <= '1;
            found_reg    <= 1'b0;
            status_reg   <= STAT_DONE;
            res_room_reg <= '0;
            res_day_reg  <= '0;
            res_nts_reg  <= '0;
            res_free_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            key_reg      <= key_next;
            room_reg     <= room_next;
            day_reg      <= day_next;
            nts_reg      <= nts_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            mid_reg      <= mid_next;
            pos_reg      <= pos_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            end_reg      <= end_next;
            up_reg       <= up_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
            max_key_reg  <= max_key_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            res_room_reg <= res_room_next;
            res_day_reg  <= res_day_next;
            res_nts_reg  <= res_nts_next;
            res_free_reg <= res_free_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
        end
    end

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // entry count moves by at most one per command
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("entry count jumped");

    // a found key never reports an error status
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && found_reg |-> (status_reg == STAT_DONE))
        else $error("found key with error status");

    // the shift source never goes above the entry count
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (CNT_W'(src_reg) <= count_reg))
        else $error("shift source outside table");

    // a command transaction always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> (state_reg != S_IDLE))
        else $error("command transaction dropped");

endmodule

// ===== dv/sorted_key_table_unit_test.sv =====
// sorted_key_table_unit_test: self-checking bench for the sorted key table
// depends on skt_pkg and sorted_key_table_unit; a directed table of commands, then
// random phases; typed jobs check fixed expected results, the rest a model
module sorted_key_table_unit_test;
    import skt_pkg::*;

    localparam int DEPTH = SKT_DEPTH;

    typedef struct packed {
        logic [DATA_W-1:0] nights;
        logic [DATA_W-1:0] start_day;
        logic [DATA_W-1:0] room;
        logic [KEY_W-1:0]  key;
        cmd_t              command;
    } table_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]  entry_count;
        status_t           status;
        logic [DATA_W-1:0] free_key;
        logic [DATA_W-1:0] nights_out;
        logic [DATA_W-1:0] start_day_out;
        logic [DATA_W-1:0] room_out;
        logic [POS_W-1:0]  position;
        logic              found;
    } table_result_t;

    typedef struct {
        table_cmd_t    c;
        bit            typed;
        table_result_t r;
    } table_job_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [KEY_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    sorted_key_table_unit #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // model copy of the table
    logic [KEY_W-1:0]  tbl_key    [DEPTH];
    logic [DATA_W-1:0] tbl_room   [DEPTH];
    logic [DATA_W-1:0] tbl_day    [DEPTH];
    logic [DATA_W-1:0] tbl_nights [DEPTH];
    int                tbl_count = 0;
    logic [KEY_W-1:0]  tbl_max_key = 16'hFFFF;

    table_job_t    job_q [$];
    table_job_t    cur_job;
    table_result_t pending_results [$];
    table_result_t got, want, pred;
    int            hold_cnt = 0;
    bit            no_gaps = 1'b0;
    int            n_mismatch = 0;
    int            n_sent = 0;
    int            n_checked = 0;
    int            n_dropped = 0;
    int            n_missed = 0;
    int            peak_count = 0;
    logic [KEY_W-1:0] last_max_key;

    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic table_result_t apply_table_cmd(input table_cmd_t c);
        table_result_t r;
        int            lo, hi, mid, pos;
        bit            hit;
        logic [KEY_W:0] nxt;
        r = '0;
        lo = 0;
        hi = tbl_count;
        pos = 0;
        hit = 1'b0;
        if (c.command != CMD_FREE)
        begin
            while (lo < hi && !hit)
            begin
                mid = (lo + hi) / 2;
                if (c.key < tbl_key[mid])
                    hi = mid;
                else if (c.key > tbl_key[mid])
                    lo = mid + 1;
                else
                begin
                    hit = 1'b1;
                    pos = mid;
                end
            end
            if (!hit)
                pos = lo;
        end
        case (c.command)
            CMD_INSERT:
                if (hit)
                begin
                    tbl_room[pos]   = c.room;
                    tbl_day[pos]    = c.start_day;
                    tbl_nights[pos] = c.nights;
                end
                else if (tbl_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_key[i]    = tbl_key[i-1];
                        tbl_room[i]   = tbl_room[i-1];
                        tbl_day[i]    = tbl_day[i-1];
                        tbl_nights[i] = tbl_nights[i-1];
                    end
                    tbl_key[pos]    = c.key;
                    tbl_room[pos]   = c.room;
                    tbl_day[pos]    = c.start_day;
                    tbl_nights[pos] = c.nights;
                    tbl_count++;
                end
            CMD_REMOVE:
                if (hit)
                begin
                    for (int i = pos; i + 1 < tbl_count; i++)
                    begin
                        tbl_key[i]    = tbl_key[i+1];
                        tbl_room[i]   = tbl_room[i+1];
                        tbl_day[i]    = tbl_day[i+1];
                        tbl_nights[i] = tbl_nights[i+1];
                    end
                    tbl_count--;
                end
                else
                    r.status = STAT_NOT_FOUND;
            CMD_LOOKUP:
                if (hit)
                begin
                    r.room_out      = tbl_room[pos];
                    r.start_day_out = tbl_day[pos];
                    r.nights_out    = tbl_nights[pos];
                end
                else
                    r.status = STAT_NOT_FOUND;
            default:
            begin
                nxt = (tbl_count > 0) ? {1'b0, tbl_key[tbl_count-1]} + (KEY_W + 1)'(1)
                                      : (KEY_W + 1)'(1);
                if (nxt < 1 || nxt > {1'b0, tbl_max_key})
                    nxt = '0;
                r.free_key = nxt[KEY_W-1:0];
                pos = 0;
                hit = 1'b0;
            end
        endcase
        r.found = hit;
        r.position = pos[POS_W-1:0];
        r.entry_count = tbl_count[POS_W-1:0];
        return r;
    endfunction

    function automatic table_cmd_t mk_cmd(input cmd_t cmd, input int k, input int rm,
                                          input int dy, input int nt);
        table_cmd_t c;
        c.command   = cmd;
        c.key       = k[KEY_W-1:0];
        c.room      = rm[DATA_W-1:0];
        c.start_day = dy[DATA_W-1:0];
        c.nights    = nt[DATA_W-1:0];
        return c;
    endfunction

    function automatic table_result_t mk_res(input bit fnd, input int pos, input int rm,
                                             input int dy, input int nt, input int fk,
                                             input status_t st, input int cnt);
        table_result_t r;
        r.found         = fnd;
        r.position      = pos[POS_W-1:0];
        r.room_out      = rm[DATA_W-1:0];
        r.start_day_out = dy[DATA_W-1:0];
        r.nights_out    = nt[DATA_W-1:0];
        r.free_key      = fk[DATA_W-1:0];
        r.status        = st;
        r.entry_count   = cnt[POS_W-1:0];
        return r;
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // command side: one transaction at a time, random holds between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pred = apply_table_cmd(cur_job.c);
                if (pred.status == STAT_FULL)
                    n_dropped++;
                if (pred.status == STAT_NOT_FOUND)
                    n_missed++;
                if (tbl_count > peak_count)
                    peak_count = tbl_count;
                pending_results.push_back(cur_job.typed ? cur_job.r : pred);
                n_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (hold_cnt > 0)
                begin
                    hold_cnt--;
                    s_tvalid <= 1'b0;
                end
                else if (job_q.size() != 0)
                begin
                    cur_job = job_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, cur_job.c};
                    hold_cnt = gap_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result side stalls
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = table_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
            n_checked++;
            if (pending_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transaction %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $display("mismatch #%0d found %0b/%0b pos %0d/%0d room %h/%h day %h/%h",
                                 n_checked, want.found, got.found, want.position,
                                 got.position, want.room_out, got.room_out,
                                 want.start_day_out, got.start_day_out);
                        $display("  nights %h/%h free %h/%h status %0d/%0d count %0d/%0d",
                                 want.nights_out, got.nights_out, want.free_key,
                                 got.free_key, want.status, got.status,
                                 want.entry_count, got.entry_count);
                        $display("  (expected/actual)");
                    end
                end
            end
        end
    end

    task automatic queue_job(input table_job_t j);
        job_q.push_back(j);
        while (job_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        while (job_q.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_key(input logic [KEY_W-1:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tbl_max_key = v;
        last_max_key = v;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int ins_w, input int rem_w, input int look_w,
                             input int key_hi, input bit fill);
        table_job_t j;
        int         r, reuse;
        int         i;
        i = 0;
        while (fill ? (tbl_count < DEPTH) : (i < n))
        begin
            r = $urandom_range(0, 99);
            if (r < ins_w)
                j.c.command = CMD_INSERT;
            else if (r < ins_w + rem_w)
                j.c.command = CMD_REMOVE;
            else if (r < ins_w + rem_w + look_w)
                j.c.command = CMD_LOOKUP;
            else
                j.c.command = CMD_FREE;
            reuse = (j.c.command == CMD_INSERT) ? 15 : 50;
            if (tbl_count != 0 && $urandom_range(0, 99) < reuse)
                j.c.key = tbl_key[$urandom_range(0, tbl_count - 1)];
            else
                j.c.key = KEY_W'($urandom_range(0, key_hi));
            j.c.room      = DATA_W'($urandom);
            j.c.start_day = DATA_W'($urandom);
            j.c.nights    = DATA_W'($urandom);
            j.typed = 1'b0;
            j.r = '0;
            queue_job(j);
            i++;
        end
    endtask

    initial
    begin
        table_job_t directed [$];
        last_max_key = 16'hFFFF;
        @(posedge rst_n);
        @(posedge clk);

        // empty table, extreme keys and payloads, replace, misses
        directed.push_back('{mk_cmd(CMD_LOOKUP, 0, 16'h1234, 16'h5678, 16'h9ABC), 1'b1,
                             mk_res(0, 0, 0, 0, 0, 0, STAT_NOT_FOUND, 0)});
        directed.push_back('{mk_cmd(CMD_REMOVE, 65535, 0, 0, 0), 1'b1,
                             mk_res(0, 0, 0, 0, 0, 0, STAT_NOT_FOUND, 0)});
        directed.push_back('{mk_cmd(CMD_FREE, 65535, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                             mk_res(0, 0, 0, 0, 0, 1, STAT_DONE, 0)});
        directed.push_back('{mk_cmd(CMD_INSERT, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                             mk_res(0, 0, 0, 0, 0, 0, STAT_DONE, 1)});
        directed.push_back('{mk_cmd(CMD_FREE, 0, 0, 0, 0), 1'b1,
                             mk_res(0, 0, 0, 0, 0, 1, STAT_DONE, 1)});
        directed.push_back('{mk_cmd(CMD_INSERT, 65535, 0, 0, 0), 1'b1,
                             mk_res(0, 1, 0, 0, 0, 0, STAT_DONE, 2)});
        directed.push_back('{mk_cmd(CMD_FREE, 0, 0, 0, 0), 1'b1,
                             mk_res(0, 0, 0, 0, 0, 0, STAT_DONE, 2)});
        directed.push_back('{mk_cmd(CMD_INSERT, 1000, 16'hA5A5, 16'h5A5A, 16'h1234), 1'b1,
                             mk_res(0, 1, 0, 0, 0, 0, STAT_DONE, 3)});
        directed.push_back('{mk_cmd(CMD_INSERT, 1000, 16'h0001, 16'h8000, 16'h7FFF), 1'b1,
                             mk_res(1, 1, 0, 0, 0, 0, STAT_DONE, 3)});
        directed.push_back('{mk_cmd(CMD_LOOKUP, 1000, 0, 0, 0), 1'b1,
                             mk_res(1, 1, 16'h0001, 16'h8000, 16'h7FFF, 0, STAT_DONE, 3)});
        directed.push_back('{mk_cmd(CMD_LOOKUP, 500, 0, 0, 0), 1'b1,
                             mk_res(0, 1, 0, 0, 0, 0, STAT_NOT_FOUND, 3)});
        directed.push_back('{mk_cmd(CMD_LOOKUP, 65535, 0, 0, 0), 1'b1,
                             mk_res(1, 2, 0, 0, 0, 0, STAT_DONE, 3)});
        directed.push_back('{mk_cmd(CMD_LOOKUP, 0, 0, 0, 0), 1'b1,
                             mk_res(1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, STAT_DONE, 3)});
        directed.push_back('{mk_cmd(CMD_REMOVE, 1000, 0, 0, 0), 1'b1,
                             mk_res(1, 1, 0, 0, 0, 0, STAT_DONE, 2)});
        directed.push_back('{mk_cmd(CMD_REMOVE, 1000, 0, 0, 0), 1'b1,
                             mk_res(0, 1, 0, 0, 0, 0, STAT_NOT_FOUND, 2)});
        directed.push_back('{mk_cmd(CMD_INSERT, 32768, 16'h00FF, 16'hFF00, 16'h0F0F), 1'b0, '0});
        directed.push_back('{mk_cmd(CMD_INSERT, 2, 16'hF0F0, 16'h3333, 16'hCCCC), 1'b0, '0});
        directed.push_back('{mk_cmd(CMD_REMOVE, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk_cmd(CMD_FREE, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk_cmd(CMD_REMOVE, 65535, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk_cmd(CMD_FREE, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk_cmd(CMD_LOOKUP, 32768, 0, 0, 0), 1'b0, '0});
        foreach (directed[i])
            queue_job(directed[i]);

        // small key range, many hits and next-free above max_key
        write_max_key(16'd40);
        no_gaps = 1'b1;
        run_phase(30, 40, 25, 25, 63, 1'b0);
        no_gaps = 1'b0;
        run_phase(60, 40, 25, 25, 63, 1'b0);

        // fill the table to the top, then work it while full
        write_max_key(16'hFFFF);
        run_phase(0, 90, 3, 4, 65535, 1'b1);
        run_phase(30, 50, 10, 25, 65535, 1'b0);

        // drain with the smallest max_key
        write_max_key(16'd1);
        run_phase(40, 5, 70, 10, 65535, 1'b0);

        write_max_key(KEY_W'($urandom_range(1, 65535)));
        run_phase(20, 30, 30, 20, 65535, 1'b0);

        wait_idle();
        repeat (300) @(posedge clk);
        $display("covered %0d command transactions, %0d inserts dropped on a full table,",
                 n_sent, n_dropped);
        $display("%0d misses, peak fill %0d of %0d, last max_key %0d, %0d results checked",
                 n_missed, peak_count, DEPTH, last_max_key, n_checked);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
